// ----- hdl/rc6_pkg.sv -----
// rc6 package: shared types, constants and word functions
`timescale 1ns / 1ps

package rc6_pkg;

    // key schedule magic constants
    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_LO     = 3'd0;
    localparam logic [2:0] REG_KEY_MID_LO = 3'd1;
    localparam logic [2:0] REG_KEY_MID_HI = 3'd2;
    localparam logic [2:0] REG_KEY_HI     = 3'd3;
    localparam logic [2:0] REG_KEY_LEN    = 3'd4;

    // request types
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_EXP_LOAD,
        ST_EXP_STEP,
        ST_IDLE,
        ST_WHITEN,
        ST_MIX,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic cfg_we;
        logic exp_load;
        logic exp_step;
        logic item_load;
        logic whiten;
        logic mix;
        logic round;
        logic fin;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic exp_last;
        logic round_last;
    } status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // quadratic mixing function x*(2x+1) rotated left by five
    function automatic logic [31:0] mix_f(input logic [31:0] x);
        logic [31:0] prod;
        prod = x * {x[30:0], 1'b1};
        return rotl32(prod, 5'd5);
    endfunction

endpackage

// ----- hdl/rc6_ctrl.sv -----
// rc6 controller: sequences key expansion and the block rounds
`timescale 1ns / 1ps

module rc6_ctrl
    import rc6_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   cfg_wr;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_EXP_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cfg_ready    = 1'b0;
        s_ready      = 1'b0;
        cfg_wr       = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_EXP_LOAD: begin
                cfg_ready    = 1'b1;
                cmd.exp_load = 1'b1;
                state_next   = ST_EXP_STEP;
            end
            ST_EXP_STEP: begin
                cfg_ready    = 1'b1;
                cmd.exp_step = 1'b1;
                if (status.exp_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (s_valid && !cfg_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_WHITEN;
                end
            end
            ST_WHITEN: begin
                cmd.whiten = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = status.round_last ? ST_FINISH : ST_MIX;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.fin      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_EXP_LOAD;
            end
        endcase
        // a key register write restarts the expansion
        cfg_wr     = cfg_valid && cfg_ready;
        cmd.cfg_we = cfg_wr;
        if (cfg_wr && (cfg_index == REG_KEY_LO || cfg_index == REG_KEY_MID_LO ||
                       cfg_index == REG_KEY_MID_HI || cfg_index == REG_KEY_HI ||
                       cfg_index == REG_KEY_LEN)) begin
            cmd.exp_load = 1'b0;
            cmd.exp_step = 1'b0;
            state_next   = ST_EXP_LOAD;
        end
    end

    // no block request is taken in the cycle of a register write
    a_cfg_vs_req: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_valid && s_ready))
        else $error("register write and block request accepted together");

    // the finish step only fires into a free output register
    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending result");

    // an accepted request is whitened in the next cycle
    a_load_whiten: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.item_load |=> cmd.whiten)
        else $error("whitening step missed");

    // a new result appears only after a finish step
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.fin))
        else $error("result valid without finish step");

endmodule

// ----- hdl/rc6_datapath.sv -----
// rc6 datapath: key registers, round key memory, key schedule and round logic
`timescale 1ns / 1ps

module rc6_datapath
    import rc6_pkg::*;
#(
    parameter int ROUNDS        = 20,
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_req_type,
    input  logic [31:0] s_word_a,
    input  logic [31:0] s_word_b,
    input  logic [31:0] s_word_c,
    input  logic [31:0] s_word_d,
    output logic [31:0] m_out_a,
    output logic [31:0] m_out_b,
    output logic [31:0] m_out_c,
    output logic [31:0] m_out_d
);

    localparam int RK_COUNT = 2 * ROUNDS + 4;
    localparam int KW_COUNT = (MAX_KEY_BYTES + 3) / 4;
    localparam int RK_AW    = $clog2(RK_COUNT);
    localparam int KW_AW    = $clog2(KW_COUNT);
    localparam int NW_W     = $clog2(KW_COUNT + 1);
    localparam int MIX_MAX  = (RK_COUNT > KW_COUNT) ? RK_COUNT : KW_COUNT;
    localparam int STEP_W   = $clog2(3 * MIX_MAX + 1);
    localparam int RND_W    = $clog2(ROUNDS + 1);

    // configuration registers
    logic [63:0] key_reg [4];
    logic [5:0]  key_len_reg;

    // round key memory and its read data
    logic [31:0]      rk_mem [RK_COUNT];
    logic [31:0]      rd0_reg, rd1_reg;
    logic [RK_AW-1:0] rd_addr;
    logic             rd0_en, rd1_en;

    // key schedule state
    logic [31:0]       kw_reg [KW_COUNT];
    logic [31:0]       kw_next [KW_COUNT];
    logic [31:0]       ea_reg, eb_reg, gen_reg;
    logic [RK_AW-1:0]  ei_reg, ei_inc;
    logic [KW_AW-1:0]  ej_reg;
    logic [NW_W-1:0]   nwords_reg, nwords_next;
    logic [STEP_W-1:0] step_reg, steps_reg, steps_next, nw_max;
    logic [5:0]        len_sat;
    logic [255:0]      key_all;
    logic [31:0]       s_val, ea_new, esum, eb_new;

    // block state
    logic [31:0]      a_reg, b_reg, c_reg, d_reg, t_reg, u_reg;
    logic             dir_reg;
    logic [RND_W-1:0] rnd_reg, rnd_step;
    logic [31:0]      out_a_reg, out_b_reg, out_c_reg, out_d_reg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0]  <= '0;
            key_reg[1]  <= '0;
            key_reg[2]  <= '0;
            key_reg[3]  <= '0;
            key_len_reg <= 6'd16;
        end else if (cmd.cfg_we) begin
            case (cfg_index)
                REG_KEY_LO:     key_reg[0]  <= cfg_data;
                REG_KEY_MID_LO: key_reg[1]  <= cfg_data;
                REG_KEY_MID_HI: key_reg[2]  <= cfg_data;
                REG_KEY_HI:     key_reg[3]  <= cfg_data;
                REG_KEY_LEN:    key_len_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // key words from the key bytes in use
    assign key_all = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign len_sat = (key_len_reg > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_len_reg;

    always_comb begin
        nwords_next = NW_W'((7'(len_sat) + 7'd3) >> 2);
        if (nwords_next == '0) begin
            nwords_next = NW_W'(1);
        end
        nw_max     = (STEP_W'(nwords_next) > STEP_W'(RK_COUNT)) ?
                     STEP_W'(nwords_next) : STEP_W'(RK_COUNT);
        steps_next = STEP_W'({nw_max, 1'b0}) + nw_max;
    end

    // one mixing step of the schedule
    assign s_val  = (step_reg < STEP_W'(RK_COUNT)) ? gen_reg : rd0_reg;
    assign ea_new = rotl32(s_val + ea_reg + eb_reg, 5'd3);
    assign esum   = ea_new + eb_reg;
    assign eb_new = rotl32(kw_reg[ej_reg] + esum, esum[4:0]);
    assign ei_inc = (ei_reg == RK_AW'(RK_COUNT - 1)) ? '0 : ei_reg + 1'b1;

    assign status.exp_last = (step_reg == steps_reg - 1'b1);

    always_comb begin
        for (int w = 0; w < KW_COUNT; w++) begin
            kw_next[w] = kw_reg[w];
            if (cmd.exp_load) begin
                for (int k = 0; k < 4; k++) begin
                    kw_next[w][8*k +: 8] = ((w * 4 + k) < int'(len_sat)) ?
                                           key_all[8*(w*4+k) +: 8] : 8'h00;
                end
            end else if (cmd.exp_step && ej_reg == KW_AW'(w)) begin
                kw_next[w] = eb_new;
            end
        end
    end

    // key schedule registers
    always_ff @(posedge aclk) begin
        for (int w = 0; w < KW_COUNT; w++) begin
            kw_reg[w] <= kw_next[w];
        end
        if (cmd.exp_load) begin
            ea_reg     <= '0;
            eb_reg     <= '0;
            gen_reg    <= MAGIC_P;
            ei_reg     <= '0;
            ej_reg     <= '0;
            step_reg   <= '0;
            nwords_reg <= nwords_next;
            steps_reg  <= steps_next;
        end else if (cmd.exp_step) begin
            ea_reg   <= ea_new;
            eb_reg   <= eb_new;
            gen_reg  <= gen_reg + MAGIC_Q;
            ei_reg   <= ei_inc;
            ej_reg   <= (NW_W'(ej_reg) == nwords_reg - 1'b1) ? '0 : ej_reg + 1'b1;
            step_reg <= step_reg + 1'b1;
        end
    end

    // round counter and read address selection
    assign status.round_last = dir_reg ? (rnd_reg == RND_W'(1)) :
                                         (rnd_reg == RND_W'(ROUNDS));
    assign rnd_step = dir_reg ? rnd_reg - 1'b1 : rnd_reg + 1'b1;

    always_comb begin
        rd_addr = '0;
        rd0_en  = 1'b0;
        rd1_en  = 1'b0;
        if (cmd.exp_step) begin
            rd_addr = ei_inc;
            rd0_en  = 1'b1;
        end else if (cmd.item_load) begin
            rd_addr = (s_req_type == REQ_DECRYPT) ? RK_AW'(2 * ROUNDS + 2) : '0;
            rd0_en  = 1'b1;
            rd1_en  = 1'b1;
        end else if (cmd.whiten) begin
            rd_addr = RK_AW'({rnd_reg, 1'b0});
            rd0_en  = 1'b1;
            rd1_en  = 1'b1;
        end else if (cmd.round) begin
            if (status.round_last) begin
                rd_addr = (dir_reg == REQ_DECRYPT) ? '0 : RK_AW'(2 * ROUNDS + 2);
            end else begin
                rd_addr = RK_AW'({rnd_step, 1'b0});
            end
            rd0_en = 1'b1;
            rd1_en = 1'b1;
        end
    end

    // round key memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.exp_step) begin
            rk_mem[ei_reg] <= ea_new;
        end
        if (rd0_en) begin
            rd0_reg <= rk_mem[rd_addr];
        end
        if (rd1_en) begin
            rd1_reg <= rk_mem[rd_addr + 1'b1];
        end
    end

    // block word registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            a_reg   <= s_word_a;
            b_reg   <= s_word_b;
            c_reg   <= s_word_c;
            d_reg   <= s_word_d;
            dir_reg <= s_req_type;
            rnd_reg <= (s_req_type == REQ_DECRYPT) ? RND_W'(ROUNDS) : RND_W'(1);
        end else if (cmd.whiten) begin
            if (dir_reg == REQ_DECRYPT) begin
                a_reg <= a_reg - rd0_reg;
                c_reg <= c_reg - rd1_reg;
            end else begin
                b_reg <= b_reg + rd0_reg;
                d_reg <= d_reg + rd1_reg;
            end
        end else if (cmd.mix) begin
            t_reg <= mix_f(dir_reg ? a_reg : b_reg);
            u_reg <= mix_f(dir_reg ? c_reg : d_reg);
        end else if (cmd.round) begin
            rnd_reg <= rnd_step;
            if (dir_reg == REQ_DECRYPT) begin
                a_reg <= rotr32(d_reg - rd0_reg, u_reg[4:0]) ^ t_reg;
                b_reg <= a_reg;
                c_reg <= rotr32(b_reg - rd1_reg, t_reg[4:0]) ^ u_reg;
                d_reg <= c_reg;
            end else begin
                a_reg <= b_reg;
                b_reg <= rotl32(c_reg ^ u_reg, t_reg[4:0]) + rd1_reg;
                c_reg <= d_reg;
                d_reg <= rotl32(a_reg ^ t_reg, u_reg[4:0]) + rd0_reg;
            end
        end
    end

    // output register with final whitening
    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            if (dir_reg == REQ_DECRYPT) begin
                out_a_reg <= a_reg;
                out_b_reg <= b_reg - rd0_reg;
                out_c_reg <= c_reg;
                out_d_reg <= d_reg - rd1_reg;
            end else begin
                out_a_reg <= a_reg + rd0_reg;
                out_b_reg <= b_reg;
                out_c_reg <= c_reg + rd1_reg;
                out_d_reg <= d_reg;
            end
        end
    end

    assign m_out_a = out_a_reg;
    assign m_out_b = out_b_reg;
    assign m_out_c = out_c_reg;
    assign m_out_d = out_d_reg;

endmodule

// ----- hdl/rc6_block_cipher_core.sv -----
// rc6 block cipher core top level
`timescale 1ns / 1ps
//
// RC6-32/ROUNDS block cipher with on-chip key expansion.
// Input channel s_*: one request is a 128-bit block (s_word_a..d) and
// s_req_type (0 encrypt, 1 decrypt); valid/ready handshake.
// Output channel m_*: one result block per request, in request order.
// Config channel cfg_*: index 0..3 write key bytes 0-31 (64 bits each),
// index 4 writes the key length in bytes; other indexes are ignored.
// A key write starts key expansion, one mixing step per cycle through the
// round key memory. Requests are held off until it completes.
// Each request runs a whitening step, then for every round a step in the
// two multipliers of the mixing function and a step in the rotate/add
// update with round key reads, then a final whitening step into the output
// register. The next request is taken only after that final step, once the
// core is back in idle.
// A result waits in the output register while the next request is
// accepted; if the receiver stalls, the next result waits in the core.
//
module rc6_block_cipher_core
    import rc6_pkg::*;
#(
    parameter int ROUNDS        = 20,
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_word_a,
    input  logic [31:0] s_word_b,
    input  logic [31:0] s_word_c,
    input  logic [31:0] s_word_d,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_a,
    output logic [31:0] m_out_b,
    output logic [31:0] m_out_c,
    output logic [31:0] m_out_d,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    rc6_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    // key schedule and round datapath
    rc6_datapath #(
        .ROUNDS        (ROUNDS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_req_type (s_req_type),
        .s_word_a   (s_word_a),
        .s_word_b   (s_word_b),
        .s_word_c   (s_word_c),
        .s_word_d   (s_word_d),
        .m_out_a    (m_out_a),
        .m_out_b    (m_out_b),
        .m_out_c    (m_out_c),
        .m_out_d    (m_out_d)
    );

endmodule
